/* rtl/jsu_pkg.sv */
// shared types, codes and helpers for the json string unescape block
package jsu_pkg;

  // result bundle sizing: one input byte gives at most four results
  localparam int MaxResults = 4;
  localparam int IdxW       = 2;
  localparam int CntW       = 3;

  // parse modes
  localparam logic [1:0] ModeIdle    = 2'd0;
  localparam logic [1:0] ModeContent = 2'd1;
  localparam logic [1:0] ModeEscape  = 2'd2;
  localparam logic [1:0] ModeHex     = 2'd3;

  // status codes
  localparam logic [2:0] StatBusy      = 3'd0;
  localparam logic [2:0] StatDone      = 3'd1;
  localparam logic [2:0] StatBadOpen   = 3'd2;
  localparam logic [2:0] StatBadEscape = 3'd3;
  localparam logic [2:0] StatBadHex    = 3'd4;
  localparam logic [2:0] StatNoClose   = 3'd5;

  // characters of interest
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharB         = 8'h62;
  localparam logic [7:0] CharF         = 8'h66;
  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharR         = 8'h72;
  localparam logic [7:0] CharT         = 8'h74;
  localparam logic [7:0] CharU         = 8'h75;
  localparam logic [7:0] CtrlMax       = 8'h1F;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       had_control_char;
  } result_t;

  // all results caused by one input byte, in order
  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [CntW-1:0]          count;
  } bundle_t;

  // decoded content byte
  function automatic result_t byte_res(input logic [7:0] b);
    result_t r;
    r.out_byte         = b;
    r.byte_valid       = 1'b1;
    r.status           = StatBusy;
    r.had_control_char = 1'b0;
    return r;
  endfunction

  // terminal status result
  function automatic result_t status_res(input logic [2:0] st, input logic ctl);
    result_t r;
    r.out_byte         = 8'h00;
    r.byte_valid       = 1'b0;
    r.status           = st;
    r.had_control_char = ctl;
    return r;
  endfunction

endpackage

/* rtl/json_string_unescape_core.sv */
// top level of the json string literal unescaper
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------------
//  item     | item_valid / item_ready    | in_byte, end_of_input
//  result   | result_valid / result_ready| out_byte, byte_valid, status,
//           |                            | had_control_char, last
//
// one input byte per cycle enters while the bundle register has room; results leave
// at one per cycle while result_ready is high; a byte's first result is presented once the
// byte has passed the input register and been decoded into the bundle register
// a byte that yields several results holds the bundle register until its last result is
// taken, and the next byte decodes as that last result transfers; bytes with no result pass
// without loading the bundle register; rst is synchronous and returns the parser to awaiting an opening quote
// a stall on result_ready backs up through the bundle and input registers
module json_string_unescape_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [2:0] status,
  output logic       had_control_char,
  output logic       last
);
  import jsu_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_eoi;
  logic       can_load;
  logic       fire;
  bundle_t    bundle;

  // decode advances when a byte is held and the bundle register has room
  assign fire = held_valid && can_load;

  jsu_in_reg u_in (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .take         (fire),
    .held_valid   (held_valid),
    .held_byte    (held_byte),
    .held_eoi     (held_eoi)
  );

  jsu_decode u_dec (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .cur_byte (held_byte),
    .cur_eoi  (held_eoi),
    .bundle   (bundle)
  );

  jsu_out_buf u_out (
    .clk              (clk),
    .rst              (rst),
    .load             (fire),
    .bundle_in        (bundle),
    .can_load         (can_load),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .out_byte         (out_byte),
    .byte_valid       (byte_valid),
    .status           (status),
    .had_control_char (had_control_char),
    .last             (last)
  );

endmodule

/* rtl/jsu_in_reg.sv */
// input register stage holding one accepted byte
module jsu_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_eoi
);
  import jsu_pkg::*;

  logic held;

  // room when empty or when the held byte moves on this cycle
  assign item_ready = !held || take;
  assign held_valid = held;

  // control flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item_ready) begin
      held <= item_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_byte <= in_byte;
      held_eoi  <= end_of_input;
    end
  end

endmodule

/* rtl/jsu_decode.sv */
// parser state and one-byte decode into a result bundle
module jsu_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic [7:0]     cur_byte,
  input  logic           cur_eoi,
  output jsu_pkg::bundle_t bundle
);
  import jsu_pkg::*;

  logic [1:0]  parse_mode, parse_mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_point, code_point_next;
  logic        control_seen, control_seen_next;

  logic        hex_ok;
  logic [3:0]  nibble_val;
  logic [15:0] cp_shift;
  logic        terminal;
  logic [CntW-1:0] n;

  // hex digit recognizer, both letter cases
  always_comb begin
    hex_ok     = 1'b1;
    nibble_val = 4'd0;
    if (cur_byte >= 8'h30 && cur_byte <= 8'h39) begin
      nibble_val = 4'(cur_byte - 8'h30);
    end else if (cur_byte >= 8'h61 && cur_byte <= 8'h66) begin
      nibble_val = 4'(cur_byte - 8'h57);
    end else if (cur_byte >= 8'h41 && cur_byte <= 8'h46) begin
      nibble_val = 4'(cur_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_shift = {code_point[11:0], nibble_val};

  // mode update and result generation
  always_comb begin
    parse_mode_next   = parse_mode;
    hex_count_next    = hex_count;
    code_point_next   = code_point;
    control_seen_next = control_seen;
    terminal          = 1'b0;
    n                 = '0;
    bundle            = '0;

    unique case (parse_mode)
      ModeIdle: begin
        if (cur_byte == CharQuote) begin
          parse_mode_next   = ModeContent;
          control_seen_next = 1'b0;
        end else begin
          bundle.res[n[IdxW-1:0]] = status_res(StatBadOpen, control_seen);
          n        = n + 1'b1;
          terminal = 1'b1;
        end
      end
      ModeContent: begin
        if (cur_byte == CharQuote) begin
          bundle.res[n[IdxW-1:0]] = status_res(StatDone, control_seen);
          n        = n + 1'b1;
          terminal = 1'b1;
        end else if (cur_byte == CharBackslash) begin
          parse_mode_next = ModeEscape;
        end else begin
          if (cur_byte <= CtrlMax) control_seen_next = 1'b1;
          bundle.res[n[IdxW-1:0]] = byte_res(cur_byte);
          n = n + 1'b1;
        end
      end
      ModeEscape: begin
        parse_mode_next = ModeContent;
        if (cur_byte == CharQuote || cur_byte == CharBackslash ||
            cur_byte == CharSlash) begin
          bundle.res[n[IdxW-1:0]] = byte_res(cur_byte);
          n = n + 1'b1;
        end else if (cur_byte == CharB) begin
          bundle.res[n[IdxW-1:0]] = byte_res(8'h08);
          n = n + 1'b1;
        end else if (cur_byte == CharF) begin
          bundle.res[n[IdxW-1:0]] = byte_res(8'h0C);
          n = n + 1'b1;
        end else if (cur_byte == CharN) begin
          bundle.res[n[IdxW-1:0]] = byte_res(8'h0A);
          n = n + 1'b1;
        end else if (cur_byte == CharR) begin
          bundle.res[n[IdxW-1:0]] = byte_res(8'h0D);
          n = n + 1'b1;
        end else if (cur_byte == CharT) begin
          bundle.res[n[IdxW-1:0]] = byte_res(8'h09);
          n = n + 1'b1;
        end else if (cur_byte == CharU) begin
          parse_mode_next = ModeHex;
          hex_count_next  = 2'd0;
          code_point_next = 16'h0000;
        end else begin
          bundle.res[n[IdxW-1:0]] = status_res(StatBadEscape, control_seen);
          n        = n + 1'b1;
          terminal = 1'b1;
        end
      end
      ModeHex: begin
        if (!hex_ok) begin
          bundle.res[n[IdxW-1:0]] = status_res(StatBadHex, control_seen);
          n        = n + 1'b1;
          terminal = 1'b1;
        end else if (hex_count != 2'd3) begin
          hex_count_next  = hex_count + 2'd1;
          code_point_next = cp_shift;
        end else begin
          // utf-8 encode of the finished code point
          if (cp_shift[15:7] == '0) begin
            bundle.res[n[IdxW-1:0]] = byte_res(cp_shift[7:0]);
            n = n + 1'b1;
          end else if (cp_shift[15:11] == '0) begin
            bundle.res[n[IdxW-1:0]] = byte_res({3'b110, cp_shift[10:6]});
            n = n + 1'b1;
            bundle.res[n[IdxW-1:0]] = byte_res({2'b10, cp_shift[5:0]});
            n = n + 1'b1;
          end else begin
            bundle.res[n[IdxW-1:0]] = byte_res({4'b1110, cp_shift[15:12]});
            n = n + 1'b1;
            bundle.res[n[IdxW-1:0]] = byte_res({2'b10, cp_shift[11:6]});
            n = n + 1'b1;
            bundle.res[n[IdxW-1:0]] = byte_res({2'b10, cp_shift[5:0]});
            n = n + 1'b1;
          end
          parse_mode_next = ModeContent;
          hex_count_next  = 2'd0;
          code_point_next = 16'h0000;
        end
      end
      default: begin
        parse_mode_next = ModeIdle;
      end
    endcase

    // input ran out inside a literal
    if (!terminal && cur_eoi && parse_mode_next != ModeIdle) begin
      bundle.res[n[IdxW-1:0]] = status_res(StatNoClose, control_seen_next);
      n        = n + 1'b1;
      terminal = 1'b1;
    end

    // any terminal status returns the parser to reset
    if (terminal) begin
      parse_mode_next   = ModeIdle;
      hex_count_next    = 2'd0;
      code_point_next   = 16'h0000;
      control_seen_next = 1'b0;
    end

    bundle.count = n;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode   <= ModeIdle;
      hex_count    <= 2'd0;
      code_point   <= 16'h0000;
      control_seen <= 1'b0;
    end else if (fire) begin
      parse_mode   <= parse_mode_next;
      hex_count    <= hex_count_next;
      code_point   <= code_point_next;
      control_seen <= control_seen_next;
    end
  end

  // digits are only collected inside a unicode escape
  a_hex_count_mode: assert property (@(posedge clk) disable iff (rst)
    hex_count != 2'd0 |-> parse_mode == ModeHex)
    else $error("hex count nonzero outside hex mode");

  a_code_point_mode: assert property (@(posedge clk) disable iff (rst)
    code_point != 16'h0000 |-> parse_mode == ModeHex)
    else $error("code point held outside hex mode");

  // control flag never survives to idle
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    parse_mode == ModeIdle |-> !control_seen)
    else $error("control flag set while idle");

endmodule

/* rtl/jsu_out_buf.sv */
// result bundle register and one-per-cycle result serializer, held while result_ready is low
module jsu_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  jsu_pkg::bundle_t bundle_in,
  output logic             can_load,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic [2:0]       status,
  output logic             had_control_char,
  output logic             last
);
  import jsu_pkg::*;

  bundle_t         bundle;
  logic [CntW-1:0] cnt;
  logic [IdxW-1:0] idx;
  logic            is_last;
  logic            take;
  result_t         cur;

  assign result_valid = (cnt != '0);
  assign is_last      = ({1'b0, idx} == cnt - CntW'(1));
  assign take         = result_valid && result_ready;
  assign can_load     = !result_valid || (take && is_last);

  // current result
  assign cur              = bundle.res[idx];
  assign out_byte         = cur.out_byte;
  assign byte_valid       = cur.byte_valid;
  assign status           = cur.status;
  assign had_control_char = cur.had_control_char;
  assign last             = is_last;

  // count and index
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load && can_load && bundle_in.count != '0) begin
      cnt <= bundle_in.count;
      idx <= '0;
    end else if (take) begin
      if (is_last) begin
        cnt <= '0;
        idx <= '0;
      end else begin
        idx <= idx + IdxW'(1);
      end
    end
  end

  // bundle payload
  always_ff @(posedge clk) begin
    if (load && can_load && bundle_in.count != '0) begin
      bundle <= bundle_in;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CntW'(MaxResults))
    else $error("bundle count out of range");

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    cnt != '0 |-> {1'b0, idx} < cnt)
    else $error("result index beyond bundle");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> cnt == $past(cnt) && idx == $past(idx))
    else $error("bundle moved while stalled");

endmodule

/* test/json_string_unescape_core_tb.sv */
// testbench for json_string_unescape_core: directed and random quoted literals checked against a decoder model
`timescale 1ns / 1ps

module json_string_unescape_core_tb;
  import jsu_pkg::*;

  // escape targets, bad escape and bad hex characters, and run sizes
  localparam logic [7:0] CodeBackspace = 8'h08;
  localparam logic [7:0] CodeFormFeed  = 8'h0C;
  localparam logic [7:0] CodeNewline   = 8'h0A;
  localparam logic [7:0] CodeReturn    = 8'h0D;
  localparam logic [7:0] CodeTab       = 8'h09;
  localparam logic [7:0] CharX         = "x";
  localparam logic [7:0] CharG         = "g";
  localparam int         LitItems      = 330;
  localparam int         MaxReports    = 10;

  typedef struct {
    logic [7:0] data;
    logic       eoi;
  } raw_byte_t;

  typedef struct {
    logic [7:0] data;
    logic       is_byte;
    logic [2:0] st;
    logic       ctl;
    logic       fin;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_input = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] status;
  logic       had_control_char;
  logic       last;

  raw_byte_t  literal_q[$];
  decoded_t   decoded_q[$];
  logic [7:0] esc_chars[8] = '{CharQuote, CharBackslash, CharSlash, CharB,
                               CharF, CharN, CharR, CharT};

  // decoder model state
  logic [1:0]  mode = ModeIdle;
  logic [1:0]  digits = 2'd0;
  logic [15:0] cp = 16'h0000;
  logic        ctl_seen = 1'b0;

  int  fail_count = 0;
  int  bytes_sent = 0;
  int  bytes_total = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  send_calm = 1'b0;
  bit  recv_calm = 1'b0;
  bit  in_fire = 1'b0;

  json_string_unescape_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .in_byte          (in_byte),
    .end_of_input     (end_of_input),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .out_byte         (out_byte),
    .byte_valid       (byte_valid),
    .status           (status),
    .had_control_char (had_control_char),
    .last             (last)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic decoded_t byte_of(input logic [7:0] b);
    decoded_t d;
    d.data    = b;
    d.is_byte = 1'b1;
    d.st      = StatBusy;
    d.ctl     = 1'b0;
    d.fin     = 1'b0;
    return d;
  endfunction

  function automatic decoded_t status_of(input logic [2:0] st);
    decoded_t d;
    d.data    = 8'h00;
    d.is_byte = 1'b0;
    d.st      = st;
    d.ctl     = ctl_seen;
    d.fin     = 1'b0;
    return d;
  endfunction

  // mostly zero, sometimes short, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // decode one transferred byte and queue the results it causes
  task automatic decode_byte(input logic [7:0] c, input logic eoi);
    decoded_t   res[$];
    logic       terminal;
    logic [3:0] nib;
    terminal = 1'b0;
    case (mode)
      ModeIdle: begin
        if (c == CharQuote) begin
          mode     = ModeContent;
          ctl_seen = 1'b0;
        end else begin
          res.push_back(status_of(StatBadOpen));
          terminal = 1'b1;
        end
      end
      ModeContent: begin
        if (c == CharQuote) begin
          res.push_back(status_of(StatDone));
          terminal = 1'b1;
        end else if (c == CharBackslash) begin
          mode = ModeEscape;
        end else begin
          if (c <= CtrlMax) ctl_seen = 1'b1;
          res.push_back(byte_of(c));
        end
      end
      ModeEscape: begin
        mode = ModeContent;
        case (c)
          CharQuote, CharBackslash, CharSlash: res.push_back(byte_of(c));
          CharB: res.push_back(byte_of(CodeBackspace));
          CharF: res.push_back(byte_of(CodeFormFeed));
          CharN: res.push_back(byte_of(CodeNewline));
          CharR: res.push_back(byte_of(CodeReturn));
          CharT: res.push_back(byte_of(CodeTab));
          CharU: begin
            mode   = ModeHex;
            digits = 2'd0;
            cp     = 16'h0000;
          end
          default: begin
            res.push_back(status_of(StatBadEscape));
            terminal = 1'b1;
          end
        endcase
      end
      default: begin
        if (!is_hex_char(c)) begin
          res.push_back(status_of(StatBadHex));
          terminal = 1'b1;
        end else begin
          // letters of either case sit at low nibble 1..6
          nib = c[3:0] + ((c >= "A") ? 4'd9 : 4'd0);
          cp  = {cp[11:0], nib};
          if (digits != 2'd3) begin
            digits = digits + 2'd1;
          end else begin
            // utf-8 encode, surrogates included
            if (cp < 16'h0080) begin
              res.push_back(byte_of(cp[7:0]));
            end else if (cp < 16'h0800) begin
              res.push_back(byte_of({3'b110, cp[10:6]}));
              res.push_back(byte_of({2'b10, cp[5:0]}));
            end else begin
              res.push_back(byte_of({4'b1110, cp[15:12]}));
              res.push_back(byte_of({2'b10, cp[11:6]}));
              res.push_back(byte_of({2'b10, cp[5:0]}));
            end
            mode   = ModeContent;
            digits = 2'd0;
            cp     = 16'h0000;
          end
        end
      end
    endcase
    if (!terminal && eoi && mode != ModeIdle) begin
      res.push_back(status_of(StatNoClose));
      terminal = 1'b1;
    end
    if (terminal) begin
      mode     = ModeIdle;
      digits   = 2'd0;
      cp       = 16'h0000;
      ctl_seen = 1'b0;
    end
    if (res.size() != 0) res[res.size()-1].fin = 1'b1;
    foreach (res[i]) decoded_q.push_back(res[i]);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic eoi);
    raw_byte_t r;
    r.data = b;
    r.eoi  = eoi;
    literal_q.push_back(r);
  endtask

  // first n hex digits of a code point, random letter case
  task automatic add_hex(input logic [15:0] val, input int n, input logic eoi_last);
    logic [3:0] nib;
    logic [7:0] ch;
    for (int k = 0; k < n; k++) begin
      nib = val[15 - 4*k -: 4];
      if (nib < 4'd10) ch = "0" + nib;
      else ch = ($urandom_range(0, 1) ? "a" : "A") + (nib - 4'd10);
      add_byte(ch, eoi_last && (k == n - 1));
    end
  endtask

  // one literal, mostly well formed, sometimes with a bad opening byte or broken at a random token
  task automatic add_literal();
    int          ntok;
    int          flaw;
    int          bad_at;
    int          kind;
    int          t;
    logic [7:0]  b;
    logic [15:0] val;
    flaw = ($urandom_range(0, 99) < 22) ? $urandom_range(1, 4) : 0;
    if (flaw == 1) begin
      do b = 8'($urandom_range(0, 255)); while (b == CharQuote);
      add_byte(b, $urandom_range(0, 3) == 0);
      return;
    end
    add_byte(CharQuote, 1'b0);
    ntok   = $urandom_range(0, 8);
    bad_at = $urandom_range(0, ntok);
    for (t = 0; t <= ntok; t++) begin
      if (flaw != 0 && t == bad_at) begin
        case (flaw)
          2: begin
            add_byte(CharBackslash, 1'b0);
            do b = 8'($urandom_range(0, 255));
            while (b == CharU || b inside {esc_chars});
            add_byte(b, 1'b0);
          end
          3: begin
            add_byte(CharBackslash, 1'b0);
            add_byte(CharU, 1'b0);
            add_hex(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3), 1'b0);
            do b = 8'($urandom_range(0, 255)); while (is_hex_char(b));
            add_byte(b, 1'b0);
          end
          default: begin
            // input runs out inside the literal
            case ($urandom_range(0, 2))
              0: begin
                do b = 8'($urandom_range(0, 255));
                while (b == CharQuote || b == CharBackslash);
                add_byte(b, 1'b1);
              end
              1: add_byte(CharBackslash, 1'b1);
              default: begin
                add_byte(CharBackslash, 1'b0);
                kind = $urandom_range(0, 3);
                add_byte(CharU, kind == 0);
                add_hex(16'($urandom_range(0, 16'hFFFF)), kind, 1'b1);
              end
            endcase
          end
        endcase
        return;
      end
      if (t == ntok) break;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        do b = 8'($urandom_range(8'h20, 8'h7E));
        while (b == CharQuote || b == CharBackslash);
        add_byte(b, 1'b0);
      end else if (kind == 4) begin
        add_byte(8'($urandom_range(0, CtrlMax)), 1'b0);
      end else if (kind == 5) begin
        add_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
      end else if (kind < 8) begin
        add_byte(CharBackslash, 1'b0);
        add_byte(esc_chars[$urandom_range(0, 7)], 1'b0);
      end else begin
        case ($urandom_range(0, 3))
          0: val = 16'($urandom_range(0, 16'h007F));
          1: val = 16'($urandom_range(16'h0080, 16'h07FF));
          2: val = 16'($urandom_range(16'hD800, 16'hDFFF));
          default: val = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        add_byte(CharBackslash, 1'b0);
        add_byte(CharU, 1'b0);
        add_hex(val, 4, 1'b0);
      end
    end
    add_byte(CharQuote, $urandom_range(0, 7) == 0);
  endtask

  // input driver: next byte after a transfer or a gap
  always @(negedge clk) begin
    raw_byte_t nxt;
    if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && !in_fire) begin
      // hold until the transfer
    end else if (send_gap != 0) begin
      item_valid <= 1'b0;
      send_gap--;
    end else if (literal_q.size() != 0) begin
      nxt = literal_q.pop_front();
      in_byte      <= nxt.data;
      end_of_input <= nxt.eoi;
      item_valid   <= 1'b1;
      send_gap = send_calm ? 0 : pick_gap();
    end else begin
      item_valid <= 1'b0;
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
    if (rst) begin
      result_ready <= 1'b0;
    end else if (stall_left != 0) begin
      result_ready <= 1'b0;
      stall_left--;
    end else begin
      result_ready <= 1'b1;
      stall_left = recv_calm ? 0 : pick_gap();
    end
  end

  // monitor: model each input transfer, check each result transfer
  always @(posedge clk) begin
    decoded_t want;
    in_fire = !rst && item_valid && item_ready;
    if (in_fire) begin
      decode_byte(in_byte, end_of_input);
      bytes_sent++;
    end
    if (!rst && result_valid && result_ready) begin
      if (decoded_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("unexpected result: byte %h valid %b status %0d ctl %b last %b",
                   out_byte, byte_valid, status, had_control_char, last);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data || byte_valid !== want.is_byte || status !== want.st ||
            had_control_char !== want.ctl || last !== want.fin) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("mismatch: exp %h/%b/%0d/%b/%b got %h/%b/%0d/%b/%b",
                     want.data, want.is_byte, want.st, want.ctl, want.fin,
                     out_byte, byte_valid, status, had_control_char, last);
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    // bad opening together with end of input
    add_byte(8'hFF, 1'b1);
    // control and high bytes, surrogate escape, then closing quote right after the digits
    add_byte(CharQuote, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(CharBackslash, 1'b0);
    add_byte(CharU, 1'b0);
    add_byte("d", 1'b0);
    add_byte("8", 1'b0);
    add_byte("0", 1'b0);
    add_byte("0", 1'b0);
    add_byte(CharQuote, 1'b0);
    // three byte escape ending the input: most results from one byte
    add_byte(CharQuote, 1'b0);
    add_byte(CharBackslash, 1'b0);
    add_byte(CharU, 1'b0);
    add_byte("F", 1'b0);
    add_byte("f", 1'b0);
    add_byte("F", 1'b0);
    add_byte("f", 1'b1);
    // illegal escape
    add_byte(CharQuote, 1'b0);
    add_byte(CharBackslash, 1'b0);
    add_byte(CharX, 1'b0);
    // bad hex digit
    add_byte(CharQuote, 1'b0);
    add_byte(CharBackslash, 1'b0);
    add_byte(CharU, 1'b0);
    add_byte("1", 1'b0);
    add_byte(CharG, 1'b0);
    while (literal_q.size() < LitItems) add_literal();
    bytes_total = literal_q.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (bytes_sent < bytes_total) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
rtl/jsu_pkg.sv
rtl/jsu_in_reg.sv
rtl/jsu_decode.sv
rtl/jsu_out_buf.sv
rtl/json_string_unescape_core.sv
test/json_string_unescape_core_tb.sv
